@@ rtl/core/scua_pkg.sv @@
// shared constants, types and class tables for the size-class unit allocator
package scua_pkg;

  localparam int unsigned MAX_UNITS       = 65536;
  localparam int unsigned NUM_CLASSES     = 38;
  localparam int unsigned MAX_BLOCK_UNITS = 128;
  localparam int unsigned AW              = 16;
  localparam int unsigned LW              = AW + 1;
  localparam int unsigned CW              = 6;
  localparam int unsigned HW              = 17;

  localparam logic [2:0] MODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_CTX    = 3'd1;
  localparam logic [2:0] MODE_ALLOC  = 3'd2;
  localparam logic [2:0] MODE_EXPAND = 3'd3;
  localparam logic [2:0] MODE_SHRINK = 3'd4;
  localparam logic [2:0] MODE_FREE   = 3'd5;

  localparam logic [4:0] OP_NONE         = 5'd0;
  localparam logic [4:0] OP_LOAD         = 5'd1;
  localparam logic [4:0] OP_INIT         = 5'd2;
  localparam logic [4:0] OP_CTX          = 5'd3;
  localparam logic [4:0] OP_BUMP         = 5'd4;
  localparam logic [4:0] OP_RES_ADDR     = 5'd5;
  localparam logic [4:0] OP_TGT_POP_CLS  = 5'd6;
  localparam logic [4:0] OP_TGT_POP_BIG  = 5'd7;
  localparam logic [4:0] OP_LINK_RD      = 5'd8;
  localparam logic [4:0] OP_POP_WR       = 5'd9;
  localparam logic [4:0] OP_PUSH_WR      = 5'd10;
  localparam logic [4:0] OP_TGT_FREE     = 5'd11;
  localparam logic [4:0] OP_RES_POP      = 5'd12;
  localparam logic [4:0] OP_SPLIT_ALLOC  = 5'd13;
  localparam logic [4:0] OP_SPLIT_SHRINK = 5'd14;
  localparam logic [4:0] OP_SPLIT_T1     = 5'd15;
  localparam logic [4:0] OP_SPLIT_T2     = 5'd16;
  localparam logic [4:0] OP_COPY_EXP     = 5'd17;
  localparam logic [4:0] OP_COPY_SHR     = 5'd18;
  localparam logic [4:0] OP_EMIT         = 5'd19;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       big128;
    logic       cls_eq;
    logic       cls_gt;
    logic       hit;
    logic       bump_fits;
    logic       ctx_fits;
    logic       found;
    logic       split_two;
  } status_t;

  function automatic logic [7:0] sat_count(input logic [7:0] n);
    logic [7:0] r;
    r = n;
    if (n == 8'd0) r = 8'd1;
    if (n > 8'd128) r = 8'd128;
    return r;
  endfunction

  // n is already in 1..128
  function automatic logic [CW-1:0] class_of(input logic [7:0] n);
    logic [7:0]  t;
    logic [11:0] m;
    logic [CW-1:0] c;
    t = 8'd0;
    m = 12'd0;
    if (n <= 8'd4) begin
      c = CW'(n - 8'd1);
    end else if (n <= 8'd12) begin
      t = (n - 8'd5) >> 1;
      c = CW'(t + 8'd4);
    end else if (n <= 8'd24) begin
      m = 12'(n - 8'd13) * 12'd11;
      c = CW'(m[11:5] + 7'd8);
    end else begin
      t = (n - 8'd25) >> 2;
      c = CW'(t + 8'd12);
    end
    return c;
  endfunction

  function automatic logic [7:0] class_units(input logic [CW-1:0] c);
    logic [7:0] u;
    case (c)
      6'd0:  u = 8'd1;
      6'd1:  u = 8'd2;
      6'd2:  u = 8'd3;
      6'd3:  u = 8'd4;
      6'd4:  u = 8'd6;
      6'd5:  u = 8'd8;
      6'd6:  u = 8'd10;
      6'd7:  u = 8'd12;
      6'd8:  u = 8'd15;
      6'd9:  u = 8'd18;
      6'd10: u = 8'd21;
      6'd11: u = 8'd24;
      default: begin
        if (c < 6'd38) u = 8'd28 + {c - 6'd12, 2'b00};
        else u = 8'd128;
      end
    endcase
    return u;
  endfunction

endpackage

@@ rtl/core/scua_req_if.sv @@
// request channel interface
interface scua_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [15:0] unit_addr;
  logic [7:0] count;
  logic [7:0] new_count;

  modport source (output valid, mode, unit_addr, count, new_count, input ready);
  modport sink (input valid, mode, unit_addr, count, new_count, output ready);
endinterface

@@ rtl/core/scua_rsp_if.sv @@
// result channel interface
interface scua_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_addr;
  logic        ok;
  logic        copy_needed;
  logic [15:0] copy_src;
  logic [7:0]  copy_units;

  modport source (output valid, result_addr, ok, copy_needed, copy_src, copy_units,
                  input ready);
  modport sink (input valid, result_addr, ok, copy_needed, copy_src, copy_units,
                output ready);
endinterface

@@ rtl/core/scua_ram.sv @@
// generic single write, single registered read ram
module scua_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/scua_dp.sv @@
// allocator datapath: marks, class heads, link store, split arithmetic and result
module scua_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scua_pkg::cmd_t      cmd_i,
  output scua_pkg::status_t   status_o,
  input  logic [2:0]          mode_i,
  input  logic [15:0]         unit_addr_i,
  input  logic [7:0]          count_i,
  input  logic [7:0]          new_count_i,
  input  logic                cfg_we_i,
  input  logic [16:0]         cfg_wdata_i,
  output logic [15:0]         result_addr_o,
  output logic                ok_o,
  output logic                copy_needed_o,
  output logic [15:0]         copy_src_o,
  output logic [7:0]          copy_units_o
);

  localparam int unsigned CW = scua_pkg::CW;
  localparam int unsigned NC = scua_pkg::NUM_CLASSES;

  logic [16:0]   heap_q;
  logic [16:0]   low_q, high_q;
  logic [NC-1:0] ne_q;
  logic [2:0]    mode_q;
  logic [15:0]   addr_q;
  logic          big128_q;
  logic [CW-1:0] cls_q, ocls_q, tcls_q, bigc_q;
  logic [15:0]   taddr_q, pop_q, p_q;
  logic [7:0]    diff_q;
  logic [15:0]   res_q, src_q;
  logic          ok_q, copy_q;
  logic [7:0]    cunits_q;
  logic [15:0]   out_addr_q, out_src_q;
  logic          out_ok_q, out_copy_q;
  logic [7:0]    out_units_q;

  logic [15:0]   head_rdata;
  logic [16:0]   link_rdata;
  logic          head_we, link_we;
  logic [15:0]   head_wdata;

  logic [7:0]    cnt_s, ncnt_s, cnt_p1;
  logic [CW-1:0] oc_in, cls_in;
  logic [16:0]   heap_lim;
  logic          found;
  logic [CW-1:0] found_c;
  logic [CW-1:0] dc, dcm1;
  logic [7:0]    cls_u, ocls_u, dcm1_u, big_u;

  assign cnt_s  = scua_pkg::sat_count(count_i);
  assign ncnt_s = scua_pkg::sat_count(new_count_i);
  assign cnt_p1 = (cnt_s == 8'd128) ? cnt_s : cnt_s + 8'd1;
  assign oc_in  = scua_pkg::class_of(cnt_s);

  always_comb begin
    case (mode_i)
      scua_pkg::MODE_CTX:    cls_in = '0;
      scua_pkg::MODE_EXPAND: cls_in = scua_pkg::class_of(cnt_p1);
      scua_pkg::MODE_SHRINK: cls_in = scua_pkg::class_of(ncnt_s);
      default:               cls_in = oc_in;
    endcase
  end

  assign heap_lim = (heap_q > 17'h10000) ? 17'h10000 : heap_q;

  always_comb begin
    found   = 1'b0;
    found_c = '0;
    for (int i = NC - 1; i >= 0; i--) begin
      if (ne_q[i] && (i > int'(cls_q))) begin
        found   = 1'b1;
        found_c = CW'(i);
      end
    end
  end

  assign cls_u  = scua_pkg::class_units(cls_q);
  assign ocls_u = scua_pkg::class_units(ocls_q);
  assign big_u  = scua_pkg::class_units(bigc_q);
  assign dc     = scua_pkg::class_of(diff_q);
  assign dcm1   = dc - CW'(1);
  assign dcm1_u = scua_pkg::class_units(dcm1);

  assign status_o.mode      = mode_q;
  assign status_o.big128    = big128_q;
  assign status_o.cls_eq    = (cls_q == ocls_q);
  assign status_o.cls_gt    = (cls_q > ocls_q);
  assign status_o.hit       = ne_q[cls_q];
  assign status_o.bump_fits = ({1'b0, low_q} + 18'(cls_u)) <= {1'b0, high_q};
  assign status_o.ctx_fits  = high_q > low_q;
  assign status_o.found     = found;
  assign status_o.split_two = (scua_pkg::class_units(dc) != diff_q) && (dc != '0);

  assign head_we    = (cmd_i.op == scua_pkg::OP_POP_WR) || (cmd_i.op == scua_pkg::OP_PUSH_WR);
  assign head_wdata = (cmd_i.op == scua_pkg::OP_POP_WR) ? link_rdata[15:0] : taddr_q;
  assign link_we    = (cmd_i.op == scua_pkg::OP_PUSH_WR);

  scua_ram #(.WIDTH(16), .DEPTH(NC)) u_head (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (tcls_q),
    .wdata_i (head_wdata),
    .raddr_i (tcls_q),
    .rdata_o (head_rdata)
  );

  scua_ram #(.WIDTH(scua_pkg::LW), .DEPTH(scua_pkg::MAX_UNITS)) u_link (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (taddr_q),
    .wdata_i ({~ne_q[tcls_q], head_rdata}),
    .raddr_i (head_rdata),
    .rdata_o (link_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q <= 17'h10000;
    end else if (cfg_we_i) begin
      heap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= 17'h10000;
      ne_q   <= '0;
    end else begin
      case (cmd_i.op)
        scua_pkg::OP_INIT: begin
          low_q  <= '0;
          high_q <= heap_lim;
          ne_q   <= '0;
        end
        scua_pkg::OP_CTX:    high_q <= high_q - 17'd1;
        scua_pkg::OP_BUMP:   low_q <= low_q + 17'(cls_u);
        scua_pkg::OP_POP_WR: ne_q[tcls_q] <= ~link_rdata[16];
        scua_pkg::OP_PUSH_WR: ne_q[tcls_q] <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      scua_pkg::OP_LOAD: begin
        mode_q   <= mode_i;
        addr_q   <= unit_addr_i;
        big128_q <= count_i >= 8'd128;
        cls_q    <= cls_in;
        ocls_q   <= oc_in;
        res_q    <= '0;
        ok_q     <= 1'b0;
        copy_q   <= 1'b0;
        src_q    <= '0;
        cunits_q <= '0;
      end
      scua_pkg::OP_INIT: ok_q <= 1'b1;
      scua_pkg::OP_CTX: begin
        res_q <= 16'(high_q - 17'd1);
        ok_q  <= 1'b1;
      end
      scua_pkg::OP_BUMP: begin
        res_q <= low_q[15:0];
        ok_q  <= 1'b1;
      end
      scua_pkg::OP_RES_ADDR: begin
        res_q <= addr_q;
        ok_q  <= 1'b1;
      end
      scua_pkg::OP_TGT_POP_CLS: tcls_q <= cls_q;
      scua_pkg::OP_TGT_POP_BIG: begin
        tcls_q <= found_c;
        bigc_q <= found_c;
      end
      scua_pkg::OP_LINK_RD: pop_q <= head_rdata;
      scua_pkg::OP_TGT_FREE: begin
        tcls_q  <= cls_q;
        taddr_q <= addr_q;
        res_q   <= addr_q;
        ok_q    <= 1'b1;
      end
      scua_pkg::OP_RES_POP: begin
        res_q <= pop_q;
        ok_q  <= 1'b1;
      end
      scua_pkg::OP_SPLIT_ALLOC: begin
        res_q  <= pop_q;
        ok_q   <= 1'b1;
        p_q    <= pop_q + 16'(cls_u);
        diff_q <= big_u - cls_u;
      end
      scua_pkg::OP_SPLIT_SHRINK: begin
        res_q  <= addr_q;
        ok_q   <= 1'b1;
        p_q    <= addr_q + 16'(cls_u);
        diff_q <= ocls_u - cls_u;
      end
      scua_pkg::OP_SPLIT_T1: begin
        tcls_q  <= dcm1;
        taddr_q <= p_q;
        p_q     <= p_q + 16'(dcm1_u);
        diff_q  <= diff_q - dcm1_u;
      end
      scua_pkg::OP_SPLIT_T2: begin
        tcls_q  <= dc;
        taddr_q <= p_q;
      end
      scua_pkg::OP_COPY_EXP: begin
        copy_q   <= 1'b1;
        src_q    <= addr_q;
        cunits_q <= ocls_u;
        tcls_q   <= ocls_q;
        taddr_q  <= addr_q;
      end
      scua_pkg::OP_COPY_SHR: begin
        res_q    <= pop_q;
        ok_q     <= 1'b1;
        copy_q   <= 1'b1;
        src_q    <= addr_q;
        cunits_q <= cls_u;
        tcls_q   <= ocls_q;
        taddr_q  <= addr_q;
      end
      scua_pkg::OP_EMIT: begin
        out_addr_q  <= res_q;
        out_ok_q    <= ok_q;
        out_copy_q  <= copy_q;
        out_src_q   <= src_q;
        out_units_q <= cunits_q;
      end
      default: ;
    endcase
  end

  assign result_addr_o = out_addr_q;
  assign ok_o          = out_ok_q;
  assign copy_needed_o = out_copy_q;
  assign copy_src_o    = out_src_q;
  assign copy_units_o  = out_units_q;

endmodule

@@ rtl/core/scua_ctrl.sv @@
// allocator controller: sequences pops, pushes, splits and the result register
module scua_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  scua_pkg::status_t status_i,
  output scua_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_ALLOC    = 4'd2;
  localparam logic [3:0] S_POP_RD   = 4'd3;
  localparam logic [3:0] S_POP_LK   = 4'd4;
  localparam logic [3:0] S_POP_WR   = 4'd5;
  localparam logic [3:0] S_AL_POP   = 4'd6;
  localparam logic [3:0] S_AL_BIG   = 4'd7;
  localparam logic [3:0] S_SPLIT    = 4'd8;
  localparam logic [3:0] S_SPLIT2   = 4'd9;
  localparam logic [3:0] S_AL_DONE  = 4'd10;
  localparam logic [3:0] S_SHR_POP  = 4'd11;
  localparam logic [3:0] S_PUSH_RD  = 4'd12;
  localparam logic [3:0] S_PUSH_WR  = 4'd13;
  localparam logic [3:0] S_FIN      = 4'd14;

  logic [3:0] state_q, state_d, ret_q, ret_d, sret_q, sret_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    sret_d     = sret_q;
    cmd_o.op   = scua_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = scua_pkg::OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_FIN;
        case (status_i.mode)
          scua_pkg::MODE_INIT: cmd_o.op = scua_pkg::OP_INIT;
          scua_pkg::MODE_CTX: begin
            if (status_i.ctx_fits) cmd_o.op = scua_pkg::OP_CTX;
            else state_d = S_ALLOC;
          end
          scua_pkg::MODE_ALLOC: state_d = S_ALLOC;
          scua_pkg::MODE_EXPAND: begin
            if (status_i.big128) state_d = S_FIN;
            else if (status_i.cls_eq) cmd_o.op = scua_pkg::OP_RES_ADDR;
            else state_d = S_ALLOC;
          end
          scua_pkg::MODE_SHRINK: begin
            if (status_i.cls_eq) begin
              cmd_o.op = scua_pkg::OP_RES_ADDR;
            end else if (status_i.cls_gt) begin
              state_d = S_FIN;
            end else if (status_i.hit) begin
              cmd_o.op = scua_pkg::OP_TGT_POP_CLS;
              ret_d    = S_SHR_POP;
              state_d  = S_POP_RD;
            end else begin
              cmd_o.op = scua_pkg::OP_SPLIT_SHRINK;
              sret_d   = S_FIN;
              state_d  = S_SPLIT;
            end
          end
          scua_pkg::MODE_FREE: begin
            cmd_o.op = scua_pkg::OP_TGT_FREE;
            ret_d    = S_FIN;
            state_d  = S_PUSH_RD;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_ALLOC: begin
        if (status_i.hit) begin
          cmd_o.op = scua_pkg::OP_TGT_POP_CLS;
          ret_d    = S_AL_POP;
          state_d  = S_POP_RD;
        end else if (status_i.bump_fits) begin
          cmd_o.op = scua_pkg::OP_BUMP;
          state_d  = S_AL_DONE;
        end else if (status_i.found) begin
          cmd_o.op = scua_pkg::OP_TGT_POP_BIG;
          ret_d    = S_AL_BIG;
          state_d  = S_POP_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_POP_RD: state_d = S_POP_LK;
      S_POP_LK: begin
        cmd_o.op = scua_pkg::OP_LINK_RD;
        state_d  = S_POP_WR;
      end
      S_POP_WR: begin
        cmd_o.op = scua_pkg::OP_POP_WR;
        state_d  = ret_q;
      end
      S_AL_POP: begin
        cmd_o.op = scua_pkg::OP_RES_POP;
        state_d  = S_AL_DONE;
      end
      S_AL_BIG: begin
        cmd_o.op = scua_pkg::OP_SPLIT_ALLOC;
        sret_d   = S_AL_DONE;
        state_d  = S_SPLIT;
      end
      S_SPLIT: begin
        if (status_i.split_two) begin
          cmd_o.op = scua_pkg::OP_SPLIT_T1;
          ret_d    = S_SPLIT2;
          state_d  = S_PUSH_RD;
        end else begin
          state_d = S_SPLIT2;
        end
      end
      S_SPLIT2: begin
        cmd_o.op = scua_pkg::OP_SPLIT_T2;
        ret_d    = sret_q;
        state_d  = S_PUSH_RD;
      end
      S_AL_DONE: begin
        if (status_i.mode == scua_pkg::MODE_EXPAND) begin
          cmd_o.op = scua_pkg::OP_COPY_EXP;
          ret_d    = S_FIN;
          state_d  = S_PUSH_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SHR_POP: begin
        cmd_o.op = scua_pkg::OP_COPY_SHR;
        ret_d    = S_FIN;
        state_d  = S_PUSH_RD;
      end
      S_PUSH_RD: state_d = S_PUSH_WR;
      S_PUSH_WR: begin
        cmd_o.op = scua_pkg::OP_PUSH_WR;
        state_d  = ret_q;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.op = scua_pkg::OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == scua_pkg::OP_EMIT) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      sret_q      <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      sret_q      <= sret_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/size_class_unit_allocator.sv @@
// top level of the size-class unit allocator
// One transaction is handled at a time; the shortest are init, context
// allocation and same-class expand or shrink, the longest an expand that splits
// a larger block into two remainders and then pushes the old block back. Any
// wait in the final state while an earlier result is still held adds to this; the length
// is set by the class-head and link memories, whose reads are registered, a pop
// needing two reads and a push one. A finished result
// waits in its own register, so the next request is taken while it is pending.
// The link store needs no clearing after reset and the block is ready at once.
module size_class_unit_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  scua_req_if.sink    req_i,
  scua_rsp_if.source  rsp_o,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i
);

  scua_pkg::cmd_t    cmd;
  scua_pkg::status_t status;

  scua_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  scua_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .mode_i        (req_i.mode),
    .unit_addr_i   (req_i.unit_addr),
    .count_i       (req_i.count),
    .new_count_i   (req_i.new_count),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_addr_o (rsp_o.result_addr),
    .ok_o          (rsp_o.ok),
    .copy_needed_o (rsp_o.copy_needed),
    .copy_src_o    (rsp_o.copy_src),
    .copy_units_o  (rsp_o.copy_units)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while busy");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ok) |-> (rsp_o.result_addr == 16'd0 && !rsp_o.copy_needed))
    else $error("failed transaction carries data");

  a_copy_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.copy_needed) |-> (rsp_o.ok && rsp_o.copy_units != 8'd0))
    else $error("copy request without success");

endmodule

@@ verif/scua_checker.sv @@
// checker for the size-class unit allocator: watches both channels, predicts and compares
`timescale 1ns / 1ps
module scua_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  scua_req_if         req,
  scua_rsp_if         rsp,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          checked_o,
  output int          waiting_o
);
  import scua_pkg::*;

  typedef struct packed {
    logic [15:0] addr;
    logic        ok;
    logic        copy;
    logic [15:0] src;
    logic [7:0]  units;
  } outcome_t;

  localparam logic [16:0] EMPTY = 17'h10000;
  localparam int unsigned SIZE_TAB [NUM_CLASSES] = '{
    1, 2, 3, 4, 6, 8, 10, 12, 15, 18, 21, 24,
    28, 32, 36, 40, 44, 48, 52, 56, 60, 64, 68, 72, 76, 80,
    84, 88, 92, 96, 100, 104, 108, 112, 116, 120, 124, 128};

  logic [16:0] free_head [NUM_CLASSES];
  logic [16:0] next_link [MAX_UNITS];
  int unsigned heap_size, low_ptr, high_ptr;
  outcome_t    awaited_results [$];

  function automatic int unsigned clamp_units(int unsigned n);
    if (n < 1) return 1;
    if (n > MAX_BLOCK_UNITS) return MAX_BLOCK_UNITS;
    return n;
  endfunction

  function automatic int size_class(int unsigned n);
    n = clamp_units(n);
    if (n <= 4) return n - 1;
    if (n <= 12) return 4 + (n - 5) / 2;
    if (n <= 24) return 8 + (n - 13) / 3;
    return 12 + (n - 25) / 4;
  endfunction

  function automatic int unsigned heap_limit();
    return (heap_size > MAX_UNITS) ? MAX_UNITS : heap_size;
  endfunction

  function automatic void list_push(int unsigned a, int c);
    a = a & 16'hffff;
    next_link[a] = free_head[c];
    free_head[c] = 17'(a);
  endfunction

  function automatic int unsigned list_pop(int c);
    int unsigned a;
    a = free_head[c][15:0];
    free_head[c] = next_link[a];
    return a;
  endfunction

  function automatic void carve(int unsigned a, int big, int sm);
    int unsigned p, diff;
    int c;
    p = a + SIZE_TAB[sm];
    diff = SIZE_TAB[big] - SIZE_TAB[sm];
    c = size_class(diff);
    if (SIZE_TAB[c] != diff && c > 0) begin
      list_push(p, c - 1);
      p += SIZE_TAB[c - 1];
      diff -= SIZE_TAB[c - 1];
    end
    list_push(p, size_class(diff));
  endfunction

  function automatic bit take_units(int unsigned num, output int unsigned a);
    int cls;
    cls = size_class(num);
    a = 0;
    if (free_head[cls] != EMPTY) begin
      a = list_pop(cls);
      return 1;
    end
    if (low_ptr + SIZE_TAB[cls] <= high_ptr) begin
      a = low_ptr & 16'hffff;
      low_ptr += SIZE_TAB[cls];
      return 1;
    end
    for (int c = cls + 1; c < NUM_CLASSES; c++) begin
      if (free_head[c] != EMPTY) begin
        a = list_pop(c);
        carve(a, c, cls);
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic outcome_t allocator_outcome(logic [2:0] mode, logic [15:0] addr,
                                                 logic [7:0] cnt_raw, logic [7:0] ncnt_raw);
    outcome_t o;
    int unsigned res, cnt, ncnt;
    int oc, nc;
    o = '0;
    res = 0;
    cnt = clamp_units(cnt_raw);
    ncnt = clamp_units(ncnt_raw);
    case (mode)
      MODE_INIT: begin
        foreach (free_head[i]) free_head[i] = EMPTY;
        low_ptr = 0;
        high_ptr = heap_limit();
        o.ok = 1;
      end
      MODE_CTX: begin
        if (high_ptr > low_ptr) begin
          high_ptr -= 1;
          res = high_ptr;
          o.ok = 1;
        end else begin
          o.ok = take_units(1, res);
        end
      end
      MODE_ALLOC: o.ok = take_units(cnt, res);
      MODE_EXPAND: begin
        if (cnt_raw < MAX_BLOCK_UNITS) begin
          oc = size_class(cnt);
          nc = size_class(cnt + 1);
          if (oc == nc) begin
            res = addr;
            o.ok = 1;
          end else if (take_units(cnt + 1, res)) begin
            o.ok = 1;
            o.copy = 1;
            o.src = addr;
            o.units = 8'(SIZE_TAB[oc]);
            list_push(addr, oc);
          end
        end
      end
      MODE_SHRINK: begin
        oc = size_class(cnt);
        nc = size_class(ncnt);
        if (oc == nc) begin
          res = addr;
          o.ok = 1;
        end else if (nc < oc) begin
          o.ok = 1;
          if (free_head[nc] != EMPTY) begin
            res = list_pop(nc);
            o.copy = 1;
            o.src = addr;
            o.units = 8'(SIZE_TAB[nc]);
            list_push(addr, oc);
          end else begin
            carve(addr, oc, nc);
            res = addr;
          end
        end
      end
      MODE_FREE: begin
        list_push(addr, size_class(cnt));
        res = addr;
        o.ok = 1;
      end
      default: ;
    endcase
    o.addr = o.ok ? 16'(res) : 16'd0;
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    checked_o = 0;
    foreach (next_link[i]) next_link[i] = '0;
  end

  assign waiting_o = awaited_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t e;
    if (!rst_ni) begin
      heap_size = 65536;
      foreach (free_head[i]) free_head[i] = EMPTY;
      low_ptr = 0;
      high_ptr = heap_limit();
    end else begin
      if (cfg_we_i) heap_size = cfg_wdata_i;
      if (rsp.valid && rsp.ready) begin
        checked_o++;
        if (awaited_results.size() == 0) begin
          report("unexpected transaction", rsp.result_addr, 0);
        end else begin
          e = awaited_results.pop_front();
          if (rsp.result_addr !== e.addr) report("result_addr", rsp.result_addr, e.addr);
          if (rsp.ok !== e.ok) report("ok", rsp.ok, e.ok);
          if (rsp.copy_needed !== e.copy) report("copy_needed", rsp.copy_needed, e.copy);
          if (rsp.copy_src !== e.src) report("copy_src", rsp.copy_src, e.src);
          if (rsp.copy_units !== e.units) report("copy_units", rsp.copy_units, e.units);
        end
      end
      if (req.valid && req.ready)
        awaited_results.push_back(allocator_outcome(req.mode, req.unit_addr,
                                                    req.count, req.new_count));
    end
  end
endmodule

@@ verif/tb.sv @@
// testbench top for the size-class unit allocator: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic [2:0]  mode;
    logic [15:0] addr;
    logic [7:0]  cnt;
    logic [7:0]  ncnt;
    bit          tracked;
  } issued_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we = 0;
  logic [16:0] cfg_wdata = '0;
  int          fails, checked, waiting;
  int          items = 0;
  int          burst = 0;

  scua_req_if req ();
  scua_rsp_if rsp ();

  issued_t     in_flight [$];
  logic [15:0] live_addr [$];
  int unsigned live_size [$];

  size_class_unit_allocator uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  scua_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req), .rsp(rsp),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fails), .checked_o(checked), .waiting_o(waiting)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int idle_gap();
    if (burst > 0) return 0;
    if ($urandom_range(0, 19) < 16) return $urandom_range(0, 2);
    return $urandom_range(8, 60);
  endfunction

  function automatic int unsigned sat(logic [7:0] n);
    if (n == 0) return 1;
    if (n > 128) return 128;
    return n;
  endfunction

  initial begin
    int g;
    rsp.ready = 0;
    forever begin
      @(negedge clk_i);
      g = idle_gap();
      if (g > 0) begin
        rsp.ready = 0;
        repeat (g - 1) @(negedge clk_i);
      end else begin
        rsp.ready = 1;
      end
    end
  end

  // result tracking keeps the list of live blocks up to date
  always @(posedge clk_i) begin
    issued_t t;
    if (rsp.valid && rsp.ready && in_flight.size() > 0) begin
      t = in_flight.pop_front();
      if (t.tracked) begin
        case (t.mode)
          scua_pkg::MODE_CTX: if (rsp.ok) begin
            live_addr.push_back(rsp.result_addr); live_size.push_back(1);
          end
          scua_pkg::MODE_ALLOC: if (rsp.ok) begin
            live_addr.push_back(rsp.result_addr); live_size.push_back(sat(t.cnt));
          end
          scua_pkg::MODE_EXPAND: begin
            live_addr.push_back(rsp.ok ? rsp.result_addr : t.addr);
            live_size.push_back(rsp.ok ? sat(t.cnt) + 1 : sat(t.cnt));
          end
          scua_pkg::MODE_SHRINK: begin
            live_addr.push_back(rsp.ok ? rsp.result_addr : t.addr);
            live_size.push_back(rsp.ok ? sat(t.ncnt) : sat(t.cnt));
          end
          default: ;
        endcase
      end
    end
  end

  task automatic send(logic [2:0] mode, logic [15:0] addr, logic [7:0] cnt,
                      logic [7:0] ncnt, bit tracked);
    int g;
    issued_t t;
    g = idle_gap();
    @(negedge clk_i);
    if (g > 0) begin
      req.valid = 0;
      repeat (g) @(negedge clk_i);
    end
    req.mode = mode;
    req.unit_addr = addr;
    req.count = cnt;
    req.new_count = ncnt;
    req.valid = 1;
    do @(posedge clk_i); while (!req.ready);
    t.mode = mode; t.addr = addr; t.cnt = cnt; t.ncnt = ncnt; t.tracked = tracked;
    in_flight.push_back(t);
    items++;
    if (burst > 0) burst--;
  endtask

  task automatic drain();
    @(negedge clk_i);
    req.valid = 0;
    while (in_flight.size() > 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(1, 24));
    if (r < 92) return 8'($urandom_range(25, 128));
    return (r < 95) ? 8'd0 : 8'($urandom_range(129, 255));
  endfunction

  // take a live block off the list; returns 0 when there is none
  function automatic bit grab(output logic [15:0] a, output int unsigned n);
    int i;
    a = 0; n = 0;
    if (live_addr.size() == 0) return 0;
    i = $urandom_range(0, live_addr.size() - 1);
    a = live_addr[i]; n = live_size[i];
    live_addr.delete(i); live_size.delete(i);
    return 1;
  endfunction

  task automatic do_expand(bit at_top);
    logic [15:0] a;
    int unsigned n;
    if (!grab(a, n)) return;
    if (at_top) send(scua_pkg::MODE_EXPAND, a, 8'($urandom_range(128, 255)), 8'd1, 0);
    else if (n >= 128) send(scua_pkg::MODE_EXPAND, a, 8'd128, 8'd1, 1);
    else send(scua_pkg::MODE_EXPAND, a, 8'(n), 8'($urandom), 1);
    if (at_top) begin
      live_addr.push_back(a); live_size.push_back(n);
    end
  endtask

  task automatic do_shrink(int how);
    logic [15:0] a;
    int unsigned n;
    logic [7:0] m;
    if (!grab(a, n)) return;
    case (how)
      0: m = 8'(n);
      1: m = 8'($urandom_range(n, 255));
      default: m = 8'($urandom_range(1, n));
    endcase
    send(scua_pkg::MODE_SHRINK, a, 8'(n), m, 1);
  endtask

  task automatic do_free();
    logic [15:0] a;
    int unsigned n;
    if (!grab(a, n)) return;
    send(scua_pkg::MODE_FREE, a, 8'(n), 8'($urandom), 0);
  endtask

  task automatic set_heap(logic [16:0] v);
    drain();
    repeat (30) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we = 0;
    send(scua_pkg::MODE_INIT, 16'($urandom), 8'($urandom), 8'($urandom), 0);
    drain();
    live_addr.delete();
    live_size.delete();
  endtask

  task automatic random_phase(int n);
    int r;
    repeat (n) begin
      if ($urandom_range(0, 49) == 0) burst = $urandom_range(10, 40);
      r = $urandom_range(0, 99);
      if (live_addr.size() == 0 && r >= 45 && r < 97) drain();
      if (r < 40) send(scua_pkg::MODE_ALLOC, 16'($urandom), pick_count(), 8'($urandom), 1);
      else if (r < 45) send(scua_pkg::MODE_CTX, 16'($urandom), 8'($urandom), 8'($urandom), 1);
      else if (r < 57) do_expand($urandom_range(0, 19) == 0);
      else if (r < 70) do_shrink($urandom_range(0, 5));
      else if (r < 97) do_free();
      else send(3'($urandom_range(6, 7)), 16'($urandom), 8'($urandom), 8'($urandom), 0);
    end
  endtask

  initial begin
    logic [7:0] bound_counts [10];
    bound_counts = '{8'd1, 8'd4, 8'd5, 8'd12, 8'd13, 8'd24, 8'd25, 8'd128, 8'd0, 8'd255};
    req.valid = 0;
    req.mode = scua_pkg::MODE_INIT;
    req.unit_addr = '0;
    req.count = '0;
    req.new_count = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: class boundaries, context, expand, shrink and free cases, unknown modes
    foreach (bound_counts[i])
      send(scua_pkg::MODE_ALLOC, 16'hffff, bound_counts[i], 8'd0, 1);
    send(scua_pkg::MODE_CTX, 16'h0, 8'd0, 8'd0, 1);
    drain();
    do_expand(1);
    do_expand(0);
    do_expand(0);
    drain();
    do_shrink(0);
    do_shrink(1);
    do_shrink(2);
    do_free();
    do_free();
    drain();
    do_shrink(2);
    send(3'd6, 16'hffff, 8'hff, 8'hff, 0);
    send(3'd7, 16'h0, 8'h0, 8'h0, 0);
    random_phase(150);
    set_heap(17'd300);
    random_phase(350);
    set_heap(17'd1);
    random_phase(80);
    set_heap(17'h1ffff);
    random_phase(250);
    set_heap(17'd65536);
    random_phase(250);

    @(negedge clk_i);
    req.valid = 0;
    drain();
    repeat (40) @(posedge clk_i);
    $display("run covered %0d requests over five heap sizes, %0d results compared",
             items, checked);
    if (fails == 0 && waiting == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d failures, %0d results outstanding", fails, waiting);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/scua_pkg.sv
rtl/core/scua_req_if.sv
rtl/core/scua_rsp_if.sv
rtl/core/scua_ram.sv
rtl/core/scua_dp.sv
rtl/core/scua_ctrl.sv
rtl/core/size_class_unit_allocator.sv
verif/scua_checker.sv
verif/tb.sv
